### design/bmr_pkg.sv
// shared types and constants for the block mean / rms / ac rms unit
`default_nettype none
package bmr_pkg;
	// block length register
	localparam logic [16:0] LenReset = 17'd256;
	localparam logic [16:0] LenMax   = 17'd65536;

	// root normalization and digit-by-digit square root
	localparam logic [63:0] NormLimit = 64'h1000_0000_0000_0000;
	localparam logic [63:0] RootTop   = 64'h4000_0000_0000_0000;

	// final counter values of the shared units
	localparam logic [5:0] MulLast = 6'd31;
	localparam logic [5:0] DivLast = 6'd48;

	// one finished block handed from front to back
	typedef struct packed {
		logic signed [32:0] sum;
		logic [46:0]        sq;
		logic [16:0]        n;
	} blk_t;

	// queue status seen by front and back
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;
endpackage
`default_nettype wire

### design/bmr_front.sv
// front end: length register, sample accumulation and block completion
`default_nettype none
module bmr_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic signed [15:0] sample,
	input  logic               sample_valid,
	output logic               sample_ready,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [16:0]        cfg_data,
	input  bmr_pkg::qstat_t    qstat,
	output logic               push,
	output bmr_pkg::blk_t      blk
);
	logic [16:0]        len_q;
	logic [16:0]        n_eff;
	logic [16:0]        cnt_q;
	logic [16:0]        cnt_nx;
	logic signed [32:0] sum_q;
	logic signed [32:0] sum_nx;
	logic [46:0]        sq_q;
	logic [46:0]        sq_nx;
	logic signed [31:0] prod;
	logic               acc;
	logic               last;

	assign cfg_ready    = 1'b1;
	assign sample_ready = !qstat.full;
	assign acc          = sample_valid && sample_ready;

	// effective block length: zero acts as one, large values saturate
	always_comb begin
		if (len_q == 17'd0) begin
			n_eff = 17'd1;
		end else if (len_q > bmr_pkg::LenMax) begin
			n_eff = bmr_pkg::LenMax;
		end else begin
			n_eff = len_q;
		end
	end

	// next sums and count
	assign prod   = sample * sample;
	assign sum_nx = sum_q + 33'(sample);
	assign sq_nx  = sq_q + {16'd0, prod[30:0]};
	assign cnt_nx = cnt_q + 17'd1;
	assign last   = cnt_nx >= n_eff;

	assign push    = acc && last;
	assign blk.sum = sum_nx;
	assign blk.sq  = sq_nx;
	assign blk.n   = n_eff;

	// accumulators and length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= bmr_pkg::LenReset;
			cnt_q <= 17'd0;
			sum_q <= 33'sd0;
			sq_q  <= 47'd0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				len_q <= cfg_data;
			end
			if (acc) begin
				if (last) begin
					cnt_q <= 17'd0;
					sum_q <= 33'sd0;
					sq_q  <= 47'd0;
				end else begin
					cnt_q <= cnt_nx;
					sum_q <= sum_nx;
					sq_q  <= sq_nx;
				end
			end
		end
	end
endmodule
`default_nettype wire

### design/bmr_queue.sv
// two-entry queue of finished blocks between front and back
`default_nettype none
module bmr_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  bmr_pkg::blk_t   wdata,
	input  logic            pop,
	output bmr_pkg::blk_t   head,
	output bmr_pkg::qstat_t qstat
);
	bmr_pkg::blk_t mem [2];
	logic          wr_q;
	logic          rd_q;
	logic [1:0]    cnt_q;

	assign head        = mem[rd_q];
	assign qstat.full  = cnt_q == 2'd2;
	assign qstat.empty = cnt_q == 2'd0;

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end
endmodule
`default_nettype wire

### design/bmr_back.sv
// back end: iterative products, divides and square roots for one block
`default_nettype none
module bmr_back (
	input  logic               clk,
	input  logic               arst_n,
	input  bmr_pkg::blk_t      head,
	input  bmr_pkg::qstat_t    qstat,
	output logic               pop,
	output logic               result_valid,
	input  logic               result_ready,
	output logic signed [31:0] mean_q16,
	output logic [31:0]        rms_q16,
	output logic [31:0]        ac_rms_q16
);
	typedef enum logic [2:0] {
		S_IDLE, S_MUL, S_MDIV, S_NORM, S_SQRT, S_RDIV, S_PUSH
	} state_t;

	state_t      state_q;
	logic [5:0]  cnt_q;
	logic        sel_q;
	logic        res_valid_q;

	// datapath registers
	logic        sign_q;
	logic [31:0] mag_q;
	logic [16:0] n_q;
	logic [63:0] mt_acc_q, mt_cand_q, ms_acc_q, ms_cand_q;
	logic [16:0] mt_plier_q;
	logic [31:0] ms_plier_q;
	logic [63:0] var_q;
	logic [63:0] v_q;
	logic [4:0]  k_q;
	logic [63:0] sq_rem_q, sq_res_q, sq_bit_q;
	logic [48:0] div_num_q, div_quo_q;
	logic [46:0] div_rem_q, div_d_q;
	logic signed [31:0] mean_q;
	logic [31:0] rms_q, ac_q;
	logic signed [31:0] mean_o_q;
	logic [31:0] rms_o_q, ac_o_q;

	// combinational helpers
	logic        start, mul_last, div_last, v_zero, norm_done, sqrt_last, push_ok;
	logic [32:0] neg_sum;
	logic [31:0] head_mag;
	logic [47:0] div_t;
	logic        div_ge;
	logic [46:0] div_rem_nx;
	logic [48:0] div_quo_nx;
	logic [63:0] sq_rb, sq_res_nx, sq_rem_nx;
	logic        sq_ge;
	logic [46:0] d_k;
	logic [31:0] mean_sat, root_sat;

	assign start     = (state_q == S_IDLE) && !qstat.empty;
	assign pop       = start;
	assign mul_last  = cnt_q == bmr_pkg::MulLast;
	assign div_last  = cnt_q == bmr_pkg::DivLast;
	assign v_zero    = v_q == 64'd0;
	assign norm_done = v_q >= bmr_pkg::NormLimit;
	assign sqrt_last = sq_bit_q[0];
	assign push_ok   = !res_valid_q || result_ready;

	assign neg_sum  = 33'(-head.sum);
	assign head_mag = head.sum[32] ? neg_sum[31:0] : head.sum[31:0];

	// restoring divider step
	assign div_t      = {div_rem_q, div_num_q[48]};
	assign div_ge     = div_t >= {1'b0, div_d_q};
	assign div_rem_nx = div_ge ? 47'(div_t - {1'b0, div_d_q}) : div_t[46:0];
	assign div_quo_nx = {div_quo_q[47:0], div_ge};

	// square root step
	assign sq_rb     = sq_res_q + sq_bit_q;
	assign sq_ge     = sq_rem_q >= sq_rb;
	assign sq_rem_nx = sq_ge ? sq_rem_q - sq_rb : sq_rem_q;
	assign sq_res_nx = sq_ge ? (sq_res_q >> 1) + sq_bit_q : sq_res_q >> 1;

	assign d_k = {30'd0, n_q} << k_q;

	// saturation of the mean and root quotients
	always_comb begin
		if (sign_q) begin
			mean_sat = (div_quo_nx > 49'h0_8000_0000) ? 32'h8000_0000
				: 32'(-div_quo_nx[31:0]);
		end else begin
			mean_sat = (div_quo_nx > 49'h0_7FFF_FFFF) ? 32'h7FFF_FFFF
				: div_quo_nx[31:0];
		end
		root_sat = (div_quo_nx > 49'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : div_quo_nx[31:0];
	end

	assign result_valid = res_valid_q;
	assign mean_q16     = mean_o_q;
	assign rms_q16      = rms_o_q;
	assign ac_rms_q16   = ac_o_q;

	// sequencer state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= 6'd0;
			sel_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && result_ready && state_q != S_PUSH) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_MUL;
						cnt_q   <= 6'd0;
					end
				end
				S_MUL: begin
					if (mul_last) begin
						state_q <= S_MDIV;
						cnt_q   <= 6'd0;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				S_MDIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (div_last) begin
						state_q <= S_NORM;
						sel_q   <= 1'b0;
					end
				end
				S_NORM: begin
					if (v_zero) begin
						if (!sel_q) begin
							sel_q <= 1'b1;
						end else begin
							state_q <= S_PUSH;
						end
					end else if (norm_done) begin
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					if (sqrt_last) begin
						state_q <= S_RDIV;
						cnt_q   <= 6'd0;
					end
				end
				S_RDIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (div_last) begin
						if (!sel_q) begin
							sel_q   <= 1'b1;
							state_q <= S_NORM;
						end else begin
							state_q <= S_PUSH;
						end
					end
				end
				S_PUSH: begin
					if (push_ok) begin
						state_q     <= S_IDLE;
						res_valid_q <= 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					sign_q     <= head.sum[32];
					mag_q      <= head_mag;
					n_q        <= head.n;
					mt_acc_q   <= 64'd0;
					ms_acc_q   <= 64'd0;
					mt_cand_q  <= {17'd0, head.sq};
					mt_plier_q <= head.n;
					ms_cand_q  <= {32'd0, head_mag};
					ms_plier_q <= head_mag;
				end
			end
			S_MUL: begin
				if (mt_plier_q[0]) begin
					mt_acc_q <= mt_acc_q + mt_cand_q;
				end
				if (ms_plier_q[0]) begin
					ms_acc_q <= ms_acc_q + ms_cand_q;
				end
				mt_cand_q  <= mt_cand_q << 1;
				ms_cand_q  <= ms_cand_q << 1;
				mt_plier_q <= mt_plier_q >> 1;
				ms_plier_q <= ms_plier_q >> 1;
				// mean divide: (mag * 65536 + n / 2) / n
				if (mul_last) begin
					div_num_q <= {1'b0, mag_q, 16'd0} + 49'(n_q >> 1);
					div_d_q   <= {30'd0, n_q};
					div_rem_q <= 47'd0;
					div_quo_q <= 49'd0;
				end
			end
			S_MDIV: begin
				div_num_q <= div_num_q << 1;
				div_rem_q <= div_rem_nx;
				div_quo_q <= div_quo_nx;
				if (div_last) begin
					mean_q <= mean_sat;
					v_q    <= mt_acc_q;
					k_q    <= 5'd0;
					var_q  <= (mt_acc_q >= ms_acc_q) ? mt_acc_q - ms_acc_q : 64'd0;
				end
			end
			S_NORM: begin
				if (v_zero) begin
					if (!sel_q) begin
						rms_q <= 32'd0;
						v_q   <= var_q;
						k_q   <= 5'd0;
					end else begin
						ac_q <= 32'd0;
					end
				end else if (!norm_done) begin
					v_q <= v_q << 2;
					k_q <= k_q + 5'd1;
				end else begin
					sq_rem_q <= v_q;
					sq_res_q <= 64'd0;
					sq_bit_q <= bmr_pkg::RootTop;
				end
			end
			S_SQRT: begin
				sq_rem_q <= sq_rem_nx;
				sq_res_q <= sq_res_nx;
				sq_bit_q <= sq_bit_q >> 2;
				// root divide: (r * 65536 + d / 2) / d, d = n << k
				if (sqrt_last) begin
					div_num_q <= {1'b0, sq_res_nx[31:0], 16'd0} + 49'(d_k >> 1);
					div_d_q   <= d_k;
					div_rem_q <= 47'd0;
					div_quo_q <= 49'd0;
				end
			end
			S_RDIV: begin
				div_num_q <= div_num_q << 1;
				div_rem_q <= div_rem_nx;
				div_quo_q <= div_quo_nx;
				if (div_last) begin
					if (!sel_q) begin
						rms_q <= root_sat;
						v_q   <= var_q;
						k_q   <= 5'd0;
					end else begin
						ac_q <= root_sat;
					end
				end
			end
			S_PUSH: begin
				if (push_ok) begin
					mean_o_q <= mean_q;
					rms_o_q  <= rms_q;
					ac_o_q   <= ac_q;
				end
			end
			default: begin
			end
		endcase
	end
endmodule
`default_nettype wire

### design/block_mean_rms_acrms_q16.sv
// top level of the block mean, rms and ac rms unit
//
// channel   direction  handshake                    payload
// sample    in         sample_valid / sample_ready  sample
// result    out        result_valid / result_ready  mean_q16, rms_q16, ac_rms_q16
// cfg       in         cfg_valid / cfg_ready        cfg_data (block_length)
//
// samples are taken one per cycle while sample_ready is high; a finished
// block is queued (two entries); per block the back end runs a start step,
// multiply steps and mean divide steps, then per nonzero root shift steps,
// a load step, root steps and divide steps (a single step for a zero root),
// and a hand-off of the result that waits while an earlier result is not
// yet taken; sample_ready drops only while both queue entries wait
// reset clears sums, count and queue and sets block_length to 256; cfg_ready
// is always high
`default_nettype none
module block_mean_rms_acrms_q16 (
	input  logic               clk,
	input  logic               arst_n,
	input  logic signed [15:0] sample,
	input  logic               sample_valid,
	output logic               sample_ready,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [16:0]        cfg_data,
	output logic               result_valid,
	input  logic               result_ready,
	output logic signed [31:0] mean_q16,
	output logic [31:0]        rms_q16,
	output logic [31:0]        ac_rms_q16
);
	bmr_pkg::blk_t   blk;
	bmr_pkg::blk_t   head;
	bmr_pkg::qstat_t qstat;
	logic            push;
	logic            pop;

	bmr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample       (sample),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.qstat        (qstat),
		.push         (push),
		.blk          (blk)
	);

	bmr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (blk),
		.pop    (pop),
		.head   (head),
		.qstat  (qstat)
	);

	bmr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.qstat        (qstat),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.mean_q16     (mean_q16),
		.rms_q16      (rms_q16),
		.ac_rms_q16   (ac_rms_q16)
	);

	// a block is queued only on an accepted sample
	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (sample_valid && sample_ready))
		else $error("block queued without a sample transaction");

	// the back end never takes from an empty queue
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("pop from empty queue");

	// a full queue holds off the sample channel
	assert property (@(posedge clk) disable iff (!arst_n)
		qstat.full |-> !sample_ready)
		else $error("sample ready while queue full");
endmodule
`default_nettype wire
